>>> design/itoa_pkg.sv
package itoa_pkg;

	localparam int VALUE_BITS   = 32;
	localparam int MAX_DIGITS   = 32;
	localparam int BITS_PER_CYC = 8;
	localparam int DIV_CYCLES   = (VALUE_BITS + BITS_PER_CYC - 1) / BITS_PER_CYC;
	localparam int DIV_W        = DIV_CYCLES * BITS_PER_CYC;
	localparam int STEP_W       = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W        = $clog2(MAX_DIGITS);

	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NONE  = 8'h00;

	localparam logic [7:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	localparam logic [15:0] RADIX_MIN = 16'd2;
	localparam logic [15:0] RADIX_MAX = 16'd16;

	typedef struct packed {
		logic [31:0] value;
		logic [15:0] radix;
		logic        negative;
	} in_t;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       last;
		logic       bad_radix;
	} out_t;

	// Source of the next output word
	typedef enum logic [1:0] {
		SEL_ERR   = 2'd0,
		SEL_ZERO  = 2'd1,
		SEL_MINUS = 2'd2,
		SEL_DIGIT = 2'd3
	} sel_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic out_load;
		sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic zero;
		logic neg;
		logic step_last;
		logic quot_zero;
		logic cnt_full;
		logic cnt_one;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return DIGIT_CHARS[d];
	endfunction

endpackage

>>> design/integer_to_ascii_any_base.sv
// Converts an unsigned magnitude to ASCII digits in any base from 2 to 16,
// most significant digit first, lower-case hex letters, with a leading '-'
// when negative is set and the magnitude is nonzero. A zero magnitude gives
// a single '0'; a base outside 2..16 gives one word with bad_radix set and
// ascii_char 0, also for a zero magnitude. The last word of each conversion
// has last set. One item is converted at a time: the digits come from a
// long division that retires 8 quotient bits per cycle, one pass over the
// whole value per digit, then leave one per cycle while result_stall is
// low. The next item is taken while the final word still waits.
module integer_to_ascii_any_base (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  itoa_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_stall,
	output itoa_pkg::out_t result
);

	itoa_pkg::cmd_t cmd;
	itoa_pkg::sts_t sts;

	itoa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	itoa_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

>>> design/itoa_dpath.sv
module itoa_dpath (
	input  logic            clk,
	input  logic            arst_n,
	input  itoa_pkg::in_t   item,
	input  itoa_pkg::cmd_t  cmd,
	output itoa_pkg::sts_t  sts,
	input  logic            result_stall,
	output logic            result_valid,
	output itoa_pkg::out_t  result
);

	logic [itoa_pkg::DIV_W-1:0]  work_q;
	logic [3:0]                  rem_q;
	logic [4:0]                  radix_q;
	logic                        neg_q;
	logic                        bad_q;
	logic                        zero_q;
	logic [itoa_pkg::STEP_W-1:0] step_q;
	logic [itoa_pkg::CNT_W-1:0]  cnt_q;
	logic [3:0]                  store_q [itoa_pkg::MAX_DIGITS];
	itoa_pkg::out_t              result_q;
	logic                        result_valid_q;

	logic [itoa_pkg::DIV_W-1:0]        in_value;
	logic [itoa_pkg::DIV_W-1:0]        value_mask;
	logic [itoa_pkg::DIV_W-1:0]        work_next;
	logic [itoa_pkg::BITS_PER_CYC-1:0] top;
	logic [itoa_pkg::BITS_PER_CYC-1:0] qbits;
	logic [3:0]                        rem_next;
	logic                              step_last;

	assign value_mask = (itoa_pkg::DIV_W'(1) << itoa_pkg::VALUE_BITS) - itoa_pkg::DIV_W'(1);
	assign in_value   = itoa_pkg::DIV_W'(item.value) & value_mask;
	assign top        = work_q[itoa_pkg::DIV_W-1 -: itoa_pkg::BITS_PER_CYC];

	// Long division, several quotient bits per cycle; the partial remainder
	// stays below the radix, so it fits in four bits.
	always_comb begin
		logic [3:0] r;
		logic [4:0] t;
		r     = rem_q;
		qbits = '0;
		for (int i = itoa_pkg::BITS_PER_CYC - 1; i >= 0; i--) begin
			t = {r, top[i]};
			if (t >= radix_q) begin
				qbits[i] = 1'b1;
				r        = 4'(t - radix_q);
			end else begin
				r = t[3:0];
			end
		end
		rem_next = r;
	end

	assign work_next = (work_q << itoa_pkg::BITS_PER_CYC) | itoa_pkg::DIV_W'(qbits);
	assign step_last = (step_q == itoa_pkg::STEP_W'(itoa_pkg::DIV_CYCLES - 1));

	always_comb begin
		sts.bad       = bad_q;
		sts.zero      = zero_q;
		sts.neg       = neg_q;
		sts.step_last = step_last;
		sts.quot_zero = (work_next == '0);
		sts.cnt_full  = (cnt_q == itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS - 1));
		sts.cnt_one   = (cnt_q == itoa_pkg::CNT_W'(1));
		sts.out_free  = !result_valid_q || !result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cnt_q  <= '0;
			rem_q  <= '0;
			bad_q  <= 1'b0;
			zero_q <= 1'b0;
			neg_q  <= 1'b0;
		end else if (cmd.load) begin
			step_q <= '0;
			cnt_q  <= '0;
			rem_q  <= '0;
			bad_q  <= (item.radix < itoa_pkg::RADIX_MIN) || (item.radix > itoa_pkg::RADIX_MAX);
			zero_q <= (in_value == '0);
			neg_q  <= item.negative;
		end else if (cmd.div_step) begin
			if (step_last) begin
				step_q <= '0;
				rem_q  <= '0;
				cnt_q  <= cnt_q + itoa_pkg::CNT_W'(1);
			end else begin
				step_q <= step_q + itoa_pkg::STEP_W'(1);
				rem_q  <= rem_next;
			end
		end else if (cmd.out_load && cmd.sel == itoa_pkg::SEL_DIGIT) begin
			cnt_q <= cnt_q - itoa_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q  <= in_value;
			radix_q <= item.radix[4:0];
		end else if (cmd.div_step) begin
			work_q <= work_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step && step_last) begin
			store_q[itoa_pkg::IDX_W'(cnt_q)] <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.sel)
				itoa_pkg::SEL_ERR: begin
					result_q <= '{ascii_char: itoa_pkg::CHAR_NONE, last: 1'b1, bad_radix: 1'b1};
				end
				itoa_pkg::SEL_ZERO: begin
					result_q <= '{ascii_char: itoa_pkg::CHAR_ZERO, last: 1'b1, bad_radix: 1'b0};
				end
				itoa_pkg::SEL_MINUS: begin
					result_q <= '{ascii_char: itoa_pkg::CHAR_MINUS, last: 1'b0, bad_radix: 1'b0};
				end
				default: begin
					result_q <= '{ascii_char: itoa_pkg::digit_char(
							store_q[itoa_pkg::IDX_W'(cnt_q - itoa_pkg::CNT_W'(1))]),
						last: sts.cnt_one, bad_radix: 1'b0};
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> design/itoa_ctrl.sv
module itoa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  itoa_pkg::sts_t sts,
	output itoa_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_CLASSIFY = 5'b00010,
		ST_DIVIDE   = 5'b00100,
		ST_SIGN     = 5'b01000,
		ST_EMIT     = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_next;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_next   = state_q;
		cmd.load     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.out_load = 1'b0;
		cmd.sel      = itoa_pkg::SEL_DIGIT;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				// bad radix and zero magnitude each give a single word
				if (sts.bad || sts.zero) begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.sel      = sts.bad ? itoa_pkg::SEL_ERR : itoa_pkg::SEL_ZERO;
						state_next   = ST_IDLE;
					end
				end else begin
					state_next = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (sts.step_last && (sts.quot_zero || sts.cnt_full)) begin
					state_next = sts.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.sel      = itoa_pkg::SEL_MINUS;
					state_next   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.sel      = itoa_pkg::SEL_DIGIT;
					if (sts.cnt_one) begin
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule
